// ----- hdl/collider_overlap_test_assert.svh -----
// Assertion macros for the checker file colo_check of collider_overlap_test.
`ifndef COLLIDER_OVERLAP_TEST_ASSERT_SVH
`define COLLIDER_OVERLAP_TEST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define COLO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define COLO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/colo_pkg.sv -----
package colo_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int CENTER_W       = 16;
  localparam int EXT_W          = 14;
  localparam int REACH_W        = EXT_W + 1;
  localparam int SQ_W           = 2 * REACH_W;
  localparam int SUM_W          = SQ_W + 1;

  typedef enum logic {
    KIND_CIRCLE = 1'b0,
    KIND_RECT   = 1'b1
  } kind_t;

  // Control that travels with each request down the pipeline.
  typedef struct packed {
    logic valid;
    logic rect;
    logic rect_hit;
  } tag_t;

endpackage

// ----- hdl/colo_reach.sv -----
module colo_reach #(
  parameter int W = 19
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  colo_pkg::tag_t                    tag_in,
  input  logic signed [W-1:0]               dx,
  input  logic signed [W-1:0]               dy,
  input  logic [colo_pkg::REACH_W-1:0]      r,
  output logic                              out_valid,
  output logic                              hit
);

  // Stage A: magnitudes and the early "too far" decision
  colo_pkg::tag_t                    a_tag;
  logic [colo_pkg::REACH_W-1:0]      a_adx;
  logic [colo_pkg::REACH_W-1:0]      a_ady;
  logic [colo_pkg::REACH_W-1:0]      a_r;
  logic                              a_far;

  logic [W-1:0] adx_next;
  logic [W-1:0] ady_next;
  logic         far_next;

  always_comb begin
    adx_next = dx[W-1] ? W'(-dx) : W'(dx);
    ady_next = dy[W-1] ? W'(-dy) : W'(dy);
    far_next = (adx_next >= W'(r)) || (ady_next >= W'(r));
  end

  // Stage B: squares
  colo_pkg::tag_t                    b_tag;
  logic [colo_pkg::SQ_W-1:0]         b_sqx;
  logic [colo_pkg::SQ_W-1:0]         b_sqy;
  logic [colo_pkg::SQ_W-1:0]         b_r2;
  logic                              b_far;

  logic [colo_pkg::SQ_W-1:0] sqx_next;
  logic [colo_pkg::SQ_W-1:0] sqy_next;
  logic [colo_pkg::SQ_W-1:0] r2_next;

  always_comb begin
    sqx_next = colo_pkg::SQ_W'(a_adx) * colo_pkg::SQ_W'(a_adx);
    sqy_next = colo_pkg::SQ_W'(a_ady) * colo_pkg::SQ_W'(a_ady);
    r2_next  = colo_pkg::SQ_W'(a_r) * colo_pkg::SQ_W'(a_r);
  end

  // Stage C: compare (or pass the rectangle pair result) into the output register
  logic [colo_pkg::SUM_W-1:0] sum_next;
  logic                       hit_next;

  always_comb begin
    sum_next = colo_pkg::SUM_W'(b_sqx) + colo_pkg::SUM_W'(b_sqy);
    if (b_tag.rect) begin
      hit_next = b_tag.rect_hit;
    end else begin
      hit_next = !b_far && (sum_next < colo_pkg::SUM_W'(b_r2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag     <= '0;
      b_tag     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      a_tag     <= tag_in;
      b_tag     <= a_tag;
      out_valid <= b_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // magnitudes below the reach fit in REACH_W bits; larger ones are masked by far
      a_adx <= adx_next[colo_pkg::REACH_W-1:0];
      a_ady <= ady_next[colo_pkg::REACH_W-1:0];
      a_r   <= r;
      a_far <= far_next;
      b_sqx <= sqx_next;
      b_sqy <= sqy_next;
      b_r2  <= r2_next;
      b_far <= a_far;
      hit   <= hit_next;
    end
  end

endmodule

// ----- hdl/collider_overlap_test.sv -----
// Strict overlap test for a pair of colliders (circle or axis-aligned rectangle each).
// One request is accepted every clock unless in_stall is high; its answer reaches the output
// through five register stages, the first one loaded at the accepting edge
// (role select and rectangle bounds, clamp of the circle center, magnitudes, squares,
// final compare). in_stall is high only while a finished result sits in the output
// register with out_stall high; the whole pipeline then holds. Centers are read as
// COORD_BITS-bit two's complement from the low bits of their ports (a COORD_BITS wider
// than the port zero-extends it); circle-with-circle runs through the same clamp path as
// a point against a zero-size rectangle with the summed radius.
module collider_overlap_test #(
  parameter int COORD_BITS = colo_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              a_kind,
  input  logic signed [colo_pkg::CENTER_W-1:0] a_center_x,
  input  logic signed [colo_pkg::CENTER_W-1:0] a_center_y,
  input  logic [colo_pkg::EXT_W-1:0]        a_extent_x,
  input  logic [colo_pkg::EXT_W-1:0]        a_extent_y,
  input  logic                              b_kind,
  input  logic signed [colo_pkg::CENTER_W-1:0] b_center_x,
  input  logic signed [colo_pkg::CENTER_W-1:0] b_center_y,
  input  logic [colo_pkg::EXT_W-1:0]        b_extent_x,
  input  logic [colo_pkg::EXT_W-1:0]        b_extent_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              overlapping
);

  localparam int CW = COORD_BITS;
  localparam int W  = ((CW > colo_pkg::EXT_W) ? CW : colo_pkg::EXT_W) + 3;

  logic advance;
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // Center extraction to COORD_BITS
  logic signed [CW-1:0] ax_c;
  logic signed [CW-1:0] ay_c;
  logic signed [CW-1:0] bx_c;
  logic signed [CW-1:0] by_c;

  generate
    if (CW <= colo_pkg::CENTER_W) begin : g_trunc
      assign ax_c = a_center_x[CW-1:0];
      assign ay_c = a_center_y[CW-1:0];
      assign bx_c = b_center_x[CW-1:0];
      assign by_c = b_center_y[CW-1:0];
    end else begin : g_zext
      assign ax_c = {{(CW-colo_pkg::CENTER_W){1'b0}}, a_center_x};
      assign ay_c = {{(CW-colo_pkg::CENTER_W){1'b0}}, a_center_y};
      assign bx_c = {{(CW-colo_pkg::CENTER_W){1'b0}}, b_center_x};
      assign by_c = {{(CW-colo_pkg::CENTER_W){1'b0}}, b_center_y};
    end
  endgenerate

  logic signed [W-1:0] ax_w, ay_w, bx_w, by_w;
  logic signed [W-1:0] aex_w, aey_w, bex_w, bey_w;

  assign ax_w  = W'(ax_c);
  assign ay_w  = W'(ay_c);
  assign bx_w  = W'(bx_c);
  assign by_w  = W'(by_c);
  assign aex_w = {{(W-colo_pkg::EXT_W){1'b0}}, a_extent_x};
  assign aey_w = {{(W-colo_pkg::EXT_W){1'b0}}, a_extent_y};
  assign bex_w = {{(W-colo_pkg::EXT_W){1'b0}}, b_extent_x};
  assign bey_w = {{(W-colo_pkg::EXT_W){1'b0}}, b_extent_y};

  // Stage 1: pick circle and rectangle roles, form bounds, rectangle pair test
  colo_pkg::tag_t                tag_next;
  logic signed [W-1:0]           cx_next, cy_next;
  logic signed [W-1:0]           rcx, rcy, hw, hh;
  logic [colo_pkg::REACH_W-1:0]  r_next;

  always_comb begin
    tag_next.valid    = in_valid;
    tag_next.rect     = 1'b0;
    tag_next.rect_hit = (ax_w - aex_w < bx_w + bex_w) && (ax_w + aex_w > bx_w - bex_w) &&
                        (ay_w - aey_w < by_w + bey_w) && (ay_w + aey_w > by_w - bey_w);
    cx_next = ax_w;
    cy_next = ay_w;
    rcx     = bx_w;
    rcy     = by_w;
    hw      = bex_w;
    hh      = bey_w;
    r_next  = colo_pkg::REACH_W'(a_extent_x);
    priority if (a_kind == colo_pkg::KIND_RECT && b_kind == colo_pkg::KIND_RECT) begin
      tag_next.rect = 1'b1;
    end else if (a_kind == colo_pkg::KIND_RECT) begin
      // swap roles: b is the circle
      cx_next = bx_w;
      cy_next = by_w;
      rcx     = ax_w;
      rcy     = ay_w;
      hw      = aex_w;
      hh      = aey_w;
      r_next  = colo_pkg::REACH_W'(b_extent_x);
    end else if (b_kind == colo_pkg::KIND_RECT) begin
      r_next  = colo_pkg::REACH_W'(a_extent_x);
    end else begin
      // two circles: point b with zero extents, summed radius
      hw     = '0;
      hh     = '0;
      r_next = colo_pkg::REACH_W'(a_extent_x) + colo_pkg::REACH_W'(b_extent_x);
    end
  end

  colo_pkg::tag_t                s1_tag;
  logic signed [W-1:0]           s1_cx, s1_cy;
  logic signed [W-1:0]           s1_lox, s1_hix, s1_loy, s1_hiy;
  logic [colo_pkg::REACH_W-1:0]  s1_r;

  // Stage 2: clamp the circle center into the rectangle and take the offset
  logic signed [W-1:0] px, py;
  logic signed [W-1:0] dx_next, dy_next;

  always_comb begin
    px = s1_cx;
    if (px > s1_hix) px = s1_hix;
    if (px < s1_lox) px = s1_lox;
    py = s1_cy;
    if (py > s1_hiy) py = s1_hiy;
    if (py < s1_loy) py = s1_loy;
    dx_next = s1_cx - px;
    dy_next = s1_cy - py;
  end

  colo_pkg::tag_t                s2_tag;
  logic signed [W-1:0]           s2_dx, s2_dy;
  logic [colo_pkg::REACH_W-1:0]  s2_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
      s2_tag <= '0;
    end else if (advance) begin
      s1_tag <= tag_next;
      s2_tag <= s1_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cx  <= cx_next;
      s1_cy  <= cy_next;
      s1_lox <= rcx - hw;
      s1_hix <= rcx + hw;
      s1_loy <= rcy - hh;
      s1_hiy <= rcy + hh;
      s1_r   <= r_next;
      s2_dx  <= dx_next;
      s2_dy  <= dy_next;
      s2_r   <= s1_r;
    end
  end

  colo_reach #(
    .W (W)
  ) u_reach (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .tag_in    (s2_tag),
    .dx        (s2_dx),
    .dy        (s2_dy),
    .r         (s2_r),
    .out_valid (out_valid),
    .hit       (overlapping)
  );

endmodule

// ----- hdl/colo_check.sv -----
`include "collider_overlap_test_assert.svh"

module colo_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              a_kind,
  input logic signed [colo_pkg::CENTER_W-1:0] a_center_x,
  input logic signed [colo_pkg::CENTER_W-1:0] a_center_y,
  input logic [colo_pkg::EXT_W-1:0]        a_extent_x,
  input logic [colo_pkg::EXT_W-1:0]        a_extent_y,
  input logic                              b_kind,
  input logic signed [colo_pkg::CENTER_W-1:0] b_center_x,
  input logic signed [colo_pkg::CENTER_W-1:0] b_center_y,
  input logic [colo_pkg::EXT_W-1:0]        b_extent_x,
  input logic [colo_pkg::EXT_W-1:0]        b_extent_y,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              overlapping
);

  // hold a stalled result
  `COLO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
  `COLO_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(overlapping),
                    "result changed under stall")
  // back-pressure only when a result is held at the output
  `COLO_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall,
                   "input stalled without output stall")
  // pipeline comes out of reset empty
  `COLO_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid, "result presented right after reset")

endmodule

bind collider_overlap_test colo_check u_colo_check (.*);
